FILE: design/ptd_pkg.sv
// Shared types, codes and helpers of the periodic task dispatcher.
package ptd_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  // Operation codes; codes ten to fifteen mean nothing and do nothing.
  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_EN_ID   = 4'd1;
  localparam logic [3:0] OP_DIS_ID  = 4'd2;
  localparam logic [3:0] OP_EN_HDL  = 4'd3;
  localparam logic [3:0] OP_DIS_HDL = 4'd4;
  localparam logic [3:0] OP_DEL_ID  = 4'd5;
  localparam logic [3:0] OP_DEL_HDL = 4'd6;
  localparam logic [3:0] OP_PER_ID  = 4'd7;
  localparam logic [3:0] OP_PER_HDL = 4'd8;
  localparam logic [3:0] OP_POLL    = 4'd9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [1:0] {
    KIND_EN  = 2'd0,
    KIND_DIS = 2'd1,
    KIND_DEL = 2'd2,
    KIND_PER = 2'd3
  } kind_t;

  typedef struct packed {
    logic        en;
    logic [31:0] last_run;
    logic [31:0] period;
    logic [7:0]  handle;
    logic [7:0]  id;
  } entry_t;

  typedef enum logic [1:0] {
    RA_IDX  = 2'd0,
    RA_SKN  = 2'd1,
    RA_LAST = 2'd2,
    RA_CUR  = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_MOD   = 3'd1,
    WR_SHIFT = 3'd2,
    WR_ADD   = 3'd3,
    WR_POLL  = 3'd4
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_NONE    = 3'd0,
    RES_FULL    = 3'd1,
    RES_NOMATCH = 3'd2,
    RES_EMPTY   = 3'd3,
    RES_ADD     = 3'd4,
    RES_DISP    = 3'd5
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    idx_inc;
    logic    idx_pc;
    logic    sk_load;
    logic    sk_inc;
    logic    del_done;
    logic    hit_set;
    logic    cur_poll;
    res_t    res;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] op;
    logic       cnt_zero;
    logic       full;
    logic       idx_end;
    logic       sk_last;
    logic       match;
    logic       due;
    logic       hit;
    logic       out_free;
  } stat_t;

  function automatic kind_t op_kind(logic [3:0] op);
    kind_t k;
    case (op)
      OP_EN_ID, OP_EN_HDL:   k = KIND_EN;
      OP_DIS_ID, OP_DIS_HDL: k = KIND_DIS;
      OP_DEL_ID, OP_DEL_HDL: k = KIND_DEL;
      default:               k = KIND_PER;
    endcase
    return k;
  endfunction

  function automatic logic op_by_handle(logic [3:0] op);
    return (op == OP_EN_HDL) || (op == OP_DIS_HDL) || (op == OP_DEL_HDL) ||
           (op == OP_PER_HDL);
  endfunction

  function automatic logic [31:0] clamp_period(logic [31:0] p);
    return (p == 32'd0) ? 32'd1 : p;
  endfunction

endpackage

FILE: design/ptd_ctrl.sv
// Sequencing state machine of the periodic task dispatcher.
module ptd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ptd_pkg::stat_t   stat,
  output ptd_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_ADD  = 9'b000000100,
    S_WALK = 9'b000001000,
    S_EVAL = 9'b000010000,
    S_SRD  = 9'b000100000,
    S_SWR  = 9'b001000000,
    S_POLL = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   by_hdl;
  ptd_pkg::kind_t kind;

  assign by_hdl    = ptd_pkg::op_by_handle(stat.op);
  assign kind      = ptd_pkg::op_kind(stat.op);
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.op)
          ptd_pkg::OP_ADD: begin
            if (stat.full) begin
              cmd.res   = ptd_pkg::RES_FULL;
              state_nxt = S_FIN;
            end else if (stat.cnt_zero) begin
              cmd.wr_sel = ptd_pkg::WR_ADD;
              cmd.res    = ptd_pkg::RES_ADD;
              state_nxt  = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ptd_pkg::RA_LAST;
              state_nxt  = S_ADD;
            end
          end
          ptd_pkg::OP_POLL: begin
            if (stat.cnt_zero) begin
              cmd.res   = ptd_pkg::RES_EMPTY;
              state_nxt = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ptd_pkg::RA_CUR;
              cmd.idx_pc = 1'b1;
              state_nxt  = S_POLL;
            end
          end
          ptd_pkg::OP_EN_ID, ptd_pkg::OP_DIS_ID, ptd_pkg::OP_EN_HDL, ptd_pkg::OP_DIS_HDL,
          ptd_pkg::OP_DEL_ID, ptd_pkg::OP_DEL_HDL, ptd_pkg::OP_PER_ID,
          ptd_pkg::OP_PER_HDL: begin
            state_nxt = S_WALK;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_ADD: begin
        cmd.wr_sel = ptd_pkg::WR_ADD;
        cmd.res    = ptd_pkg::RES_ADD;
        state_nxt  = S_FIN;
      end
      S_WALK: begin
        if (stat.idx_end) begin
          if (!stat.hit) begin
            cmd.res = ptd_pkg::RES_NOMATCH;
          end
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ptd_pkg::RA_IDX;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.match) begin
          cmd.hit_set = 1'b1;
          if (kind == ptd_pkg::KIND_DEL) begin
            cmd.sk_load = 1'b1;
            state_nxt   = S_SRD;
          end else begin
            cmd.wr_sel = ptd_pkg::WR_MOD;
            if (by_hdl) begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_WALK;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_WALK;
        end
      end
      S_SRD: begin
        if (stat.sk_last) begin
          cmd.del_done = 1'b1;
          state_nxt    = by_hdl ? S_WALK : S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ptd_pkg::RA_SKN;
          state_nxt  = S_SWR;
        end
      end
      S_SWR: begin
        cmd.wr_sel = ptd_pkg::WR_SHIFT;
        cmd.sk_inc = 1'b1;
        state_nxt  = S_SRD;
      end
      S_POLL: begin
        cmd.cur_poll = 1'b1;
        if (stat.due) begin
          cmd.wr_sel = ptd_pkg::WR_POLL;
          cmd.res    = ptd_pkg::RES_DISP;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/ptd_dp.sv
// Task table memory, counters and result register of the periodic task dispatcher.
module ptd_dp #(
  parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ptd_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ptd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  ptd_pkg::cmd_t                 cmd,
  output ptd_pkg::stat_t                stat
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  ptd_pkg::entry_t mem [MAX_TASKS];
  ptd_pkg::entry_t rd_q;

  // Captured item.
  logic [3:0]  op_r;
  logic [7:0]  tid_r;
  logic [7:0]  th_r;
  logic [31:0] per_r;
  logic        en_r;
  logic [31:0] now_r;

  logic [CW-1:0] count_r, cursor_r, idx_r, sk_r;
  logic          hit_r;

  // Result being built and the output register.
  logic        disp_r;
  logic [7:0]  rh_r, rid_r, aid_r;
  logic [1:0]  st_r;
  logic        out_valid_r;
  logic [26:0] out_r;

  logic [CW-1:0]   pc, raddr_c, waddr_c, sk_nxt_c;
  logic [CW:0]     sk_plus;
  logic [7:0]      new_id, key, rd_key;
  logic            wr_en;
  ptd_pkg::entry_t wdata;
  ptd_pkg::kind_t  kind;

  assign kind     = ptd_pkg::op_kind(op_r);
  assign pc       = (cursor_r >= count_r) ? '0 : cursor_r;
  assign sk_plus  = {1'b0, sk_r} + {{CW{1'b0}}, 1'b1};
  assign sk_nxt_c = sk_plus[CW-1:0];
  assign new_id   = (count_r == '0) ? 8'd0 : rd_q.id + 8'd1;
  assign key      = ptd_pkg::op_by_handle(op_r) ? th_r : tid_r;
  assign rd_key   = ptd_pkg::op_by_handle(op_r) ? rd_q.handle : rd_q.id;

  always_comb begin
    case (cmd.rd_sel)
      ptd_pkg::RA_IDX:  raddr_c = idx_r;
      ptd_pkg::RA_SKN:  raddr_c = sk_nxt_c;
      ptd_pkg::RA_LAST: raddr_c = count_r - CNT_ONE;
      ptd_pkg::RA_CUR:  raddr_c = pc;
      default:          raddr_c = idx_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    waddr_c = idx_r;
    wdata   = rd_q;
    case (cmd.wr_sel)
      ptd_pkg::WR_MOD: begin
        case (kind)
          ptd_pkg::KIND_EN:  wdata.en = 1'b1;
          ptd_pkg::KIND_DIS: wdata.en = 1'b0;
          ptd_pkg::KIND_PER: wdata.period = ptd_pkg::clamp_period(per_r);
          default:           wdata = rd_q;
        endcase
      end
      ptd_pkg::WR_SHIFT: begin
        waddr_c = sk_r;
      end
      ptd_pkg::WR_ADD: begin
        waddr_c        = count_r;
        wdata.id       = new_id;
        wdata.handle   = th_r;
        wdata.period   = ptd_pkg::clamp_period(per_r);
        wdata.last_run = 32'd0;
        wdata.en       = en_r;
      end
      ptd_pkg::WR_POLL: begin
        wdata.last_run = now_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr_c[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[raddr_c[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tdata[3:0];
      tid_r <= in_tdata[11:4];
      th_r  <= in_tdata[19:12];
      per_r <= in_tdata[51:20];
      en_r  <= in_tdata[52];
      now_r <= in_tdata[84:53];
    end
    if (cmd.load) begin
      disp_r <= 1'b0;
      rh_r   <= 8'd0;
      rid_r  <= 8'd0;
      aid_r  <= 8'd0;
      st_r   <= ptd_pkg::ST_OK;
    end else begin
      case (cmd.res)
        ptd_pkg::RES_FULL:    st_r <= ptd_pkg::ST_FULL;
        ptd_pkg::RES_NOMATCH: st_r <= ptd_pkg::ST_NOMATCH;
        ptd_pkg::RES_EMPTY:   st_r <= ptd_pkg::ST_EMPTY;
        ptd_pkg::RES_ADD:     aid_r <= new_id;
        ptd_pkg::RES_DISP: begin
          disp_r <= 1'b1;
          rh_r   <= rd_q.handle;
          rid_r  <= rd_q.id;
        end
        default: begin
        end
      endcase
    end
    if (cmd.out_load) begin
      out_r <= {st_r, aid_r, rid_r, rh_r, disp_r};
    end
    if (cmd.sk_load) begin
      sk_r <= idx_r;
    end else if (cmd.sk_inc) begin
      sk_r <= sk_nxt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.idx_pc) begin
        idx_r <= pc;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CNT_ONE;
      end
      if (cmd.hit_set) begin
        hit_r <= 1'b1;
      end
      if (cmd.wr_sel == ptd_pkg::WR_ADD) begin
        count_r <= count_r + CNT_ONE;
        if (cursor_r >= count_r) begin
          cursor_r <= count_r + CNT_ONE;
        end
      end else if (cmd.del_done) begin
        count_r <= count_r - CNT_ONE;
        if (cursor_r > idx_r) begin
          cursor_r <= cursor_r - CNT_ONE;
        end
      end else if (cmd.cur_poll) begin
        cursor_r <= idx_r + CNT_ONE;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.op       = op_r;
    stat.cnt_zero = (count_r == '0);
    stat.full     = (count_r >= CNT_MAX);
    stat.idx_end  = (idx_r >= count_r);
    stat.sk_last  = (sk_plus >= {1'b0, count_r});
    stat.match    = (rd_key == key);
    stat.due      = rd_q.en && ((now_r - rd_q.last_run) >= rd_q.period);
    stat.hit      = hit_r;
    stat.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r};

endmodule

FILE: design/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: controller plus table datapath.
//
//  Channel  Direction  Word contents
//  in_*     slave      op, id, handle, period, start enable, now (88-bit tdata)
//  out_*    master     dispatch, run handle, run id, assigned id, status (32-bit tdata)
//
// Each word runs one operation to completion before the next word is taken.
// An add reads the last entry for the new id and then writes; a poll reads the entry at
// the cursor and writes it back if due. An add to an empty table, a poll of an empty
// table and an unknown code skip the read. A lookup reads and tests one entry at a
// time, and a delete moves each later entry down by a read and a write. The worst case
// is a delete by handle that removes every entry.
// Reset (rst_n, synchronous) empties the table and parks the cursor at list end.
// A finished result waits in the output register while the next word is taken.
module periodic_task_dispatcher #(
  parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [3:0] operation, [11:4] task_id, [19:12] task_handle, [51:20] period_ms,
  // [52] start_enabled, [84:53] now_ms, [87:85] zero
  input  logic [ptd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] dispatch, [8:1] run_handle, [16:9] run_id, [24:17] assigned_id,
  // [26:25] status, [31:27] zero
  output logic [ptd_pkg::OUT_DATA_W-1:0] out_tdata
);

  // Commands and status between the sequencer and the table datapath.
  ptd_pkg::cmd_t  cmd;
  ptd_pkg::stat_t stat;

  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptd_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
